// ===== design/pcc_pkg.sv =====
// ----------------------------------------------------------------------------
// pcc_pkg
// Shared types and constants of the pump condition controller: condition word
// fields, register indexes, queue sizing and the words passed between stages.
// ----------------------------------------------------------------------------
package pcc_pkg;

    // condition word layout
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned VALUE_W    = 16;
    localparam int unsigned MODE_LSB   = 16;
    localparam int unsigned INV_BIT    = 31;
    localparam int unsigned RUN_W      = 16;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W  = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_TRIGGER = 2'd0,
        REG_STOP_A  = 2'd1,
        REG_STOP_B  = 2'd2,
        REG_NONE    = 2'd3
    } t_reg_idx;

    // condition mode field
    typedef enum logic [1:0] {
        MODE_NEVER   = 2'd0,
        MODE_SENSOR  = 2'd1,
        MODE_RUNTIME = 2'd2,
        MODE_TRUE    = 2'd3
    } t_mode;

    // condition after classification, still to be resolved against pump state
    typedef enum logic [1:0] {
        CK_FALSE   = 2'd0,
        CK_TRUE    = 2'd1,
        CK_RUN     = 2'd2,
        CK_RUN_INV = 2'd3
    } t_cond_kind;

    // queue sizing, shared by both stages
    localparam int unsigned QDEPTH = 2;
    localparam int unsigned QPTR_W = $clog2(QDEPTH);
    localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

    // classified evaluation passed from front to back
    typedef struct packed {
        logic [WORD_W-1:0]  now;
        logic               oper;
        t_cond_kind         kind_trig;
        t_cond_kind         kind_a;
        t_cond_kind         kind_b;
        logic [VALUE_W-1:0] val_trig;
        logic [VALUE_W-1:0] val_a;
        logic [VALUE_W-1:0] val_b;
    } t_work;

    // one result word
    typedef struct packed {
        logic              pump_on;
        logic              conflict;
        logic [WORD_W-1:0] stopped_for;
        logic [RUN_W-1:0]  running_for;
    } t_result;

endpackage

// ===== design/pcc_front.sv =====
// ----------------------------------------------------------------------------
// pcc_front
// Holds the condition registers, accepts evaluation words, classifies each
// condition as far as it can without pump state and queues the result.
// ----------------------------------------------------------------------------
module pcc_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pcc_pkg::WORD_W-1:0]         i_cfg_data,
    input  logic                               i_push,
    output logic                               o_full,
    input  logic [pcc_pkg::WORD_W-1:0]         i_now_seconds,
    input  logic                               i_operational,
    input  logic                               i_sensor_for_trigger,
    input  logic                               i_sensor_for_stop_a,
    input  logic                               i_sensor_for_stop_b,
    output pcc_pkg::t_work                     o_work,
    output logic                               o_work_valid,
    input  logic                               i_work_take
);

    logic [pcc_pkg::WORD_W-1:0] r_trig_cond;
    logic [pcc_pkg::WORD_W-1:0] r_stop_a_cond;
    logic [pcc_pkg::WORD_W-1:0] r_stop_b_cond;

    pcc_pkg::t_work             r_q [pcc_pkg::QDEPTH];
    logic [pcc_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [pcc_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [pcc_pkg::QCNT_W-1:0] r_count;

    pcc_pkg::t_work             n_work;
    logic                       accept;
    logic                       take;

    // resolve what a condition word can resolve without pump state
    function automatic pcc_pkg::t_cond_kind classify(
        input logic [pcc_pkg::WORD_W-1:0] word,
        input logic                       sensor
    );
        pcc_pkg::t_mode     mode;
        logic               inv;
        pcc_pkg::t_cond_kind kind;
        mode = pcc_pkg::t_mode'(word[pcc_pkg::MODE_LSB +: 2]);
        inv  = word[pcc_pkg::INV_BIT];
        case (mode)
            pcc_pkg::MODE_NEVER:   kind = pcc_pkg::CK_FALSE;
            pcc_pkg::MODE_SENSOR:  kind = (sensor ^ inv) ? pcc_pkg::CK_TRUE
                                                         : pcc_pkg::CK_FALSE;
            pcc_pkg::MODE_RUNTIME: kind = inv ? pcc_pkg::CK_RUN_INV
                                              : pcc_pkg::CK_RUN;
            pcc_pkg::MODE_TRUE:    kind = inv ? pcc_pkg::CK_FALSE
                                              : pcc_pkg::CK_TRUE;
            default:               kind = pcc_pkg::CK_FALSE;
        endcase
        return kind;
    endfunction

    // condition registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trig_cond   <= '0;
            r_stop_a_cond <= '0;
            r_stop_b_cond <= '0;
        end else if (i_cfg_we) begin
            case (pcc_pkg::t_reg_idx'(i_cfg_index))
                pcc_pkg::REG_TRIGGER: r_trig_cond   <= i_cfg_data;
                pcc_pkg::REG_STOP_A:  r_stop_a_cond <= i_cfg_data;
                pcc_pkg::REG_STOP_B:  r_stop_b_cond <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // classify the incoming word
    always_comb begin
        n_work.now       = i_now_seconds;
        n_work.oper      = i_operational;
        n_work.kind_trig = classify(r_trig_cond, i_sensor_for_trigger);
        n_work.kind_a    = classify(r_stop_a_cond, i_sensor_for_stop_a);
        n_work.kind_b    = classify(r_stop_b_cond, i_sensor_for_stop_b);
        n_work.val_trig  = r_trig_cond[pcc_pkg::VALUE_W-1:0];
        n_work.val_a     = r_stop_a_cond[pcc_pkg::VALUE_W-1:0];
        n_work.val_b     = r_stop_b_cond[pcc_pkg::VALUE_W-1:0];
    end

    assign o_full       = (r_count == pcc_pkg::QCNT_W'(pcc_pkg::QDEPTH));
    assign accept       = i_push && !o_full;
    assign o_work_valid = (r_count != '0);
    assign take         = i_work_take && o_work_valid;
    assign o_work       = r_q[r_rd_ptr];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wr_ptr] <= n_work;
        end
    end

    // queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (accept) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (take) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (accept && !take) begin
                r_count <= r_count + 1'b1;
            end else if (take && !accept) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/pcc_back.sv =====
// ----------------------------------------------------------------------------
// pcc_back
// Resolves classified conditions against pump state, updates the pump state
// and the start and stop times, and queues one result word per evaluation.
// ----------------------------------------------------------------------------
module pcc_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_trig_written,
    input  pcc_pkg::t_work                 i_work,
    input  logic                           i_work_valid,
    output logic                           o_work_take,
    output logic                           o_empty,
    input  logic                           i_pop,
    output logic                           o_pump_on,
    output logic                           o_conflict_error,
    output logic [pcc_pkg::WORD_W-1:0]     o_stopped_for_s,
    output logic [pcc_pkg::RUN_W-1:0]      o_running_for_s
);

    logic                       r_running;
    logic [pcc_pkg::WORD_W-1:0] r_start;
    logic [pcc_pkg::WORD_W-1:0] r_stop;
    logic                       r_blocked;

    pcc_pkg::t_result           r_q [pcc_pkg::QDEPTH];
    logic [pcc_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [pcc_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [pcc_pkg::QCNT_W-1:0] r_count;

    logic                       n_running;
    logic [pcc_pkg::WORD_W-1:0] n_start;
    logic [pcc_pkg::WORD_W-1:0] n_stop;
    logic                       n_blocked;
    pcc_pkg::t_result           n_result;

    logic [pcc_pkg::WORD_W-1:0] elapsed;
    logic                       trig;
    logic                       stop;
    logic                       err;
    logic                       fire;
    logic                       pop_ok;
    logic [pcc_pkg::WORD_W-1:0] run_diff;

    // resolve one classified condition
    function automatic logic resolve(
        input pcc_pkg::t_cond_kind        kind,
        input logic [pcc_pkg::VALUE_W-1:0] val,
        input logic                        running,
        input logic [pcc_pkg::WORD_W-1:0]  el
    );
        logic hit;
        logic r;
        hit = running && (el >= {{(pcc_pkg::WORD_W - pcc_pkg::VALUE_W){1'b0}}, val});
        case (kind)
            pcc_pkg::CK_FALSE:   r = 1'b0;
            pcc_pkg::CK_TRUE:    r = 1'b1;
            pcc_pkg::CK_RUN:     r = hit;
            pcc_pkg::CK_RUN_INV: r = !hit;
            default:             r = 1'b0;
        endcase
        return r;
    endfunction

    // advance when a word waits and the result queue has room
    assign o_empty     = (r_count == '0);
    assign pop_ok      = i_pop && !o_empty;
    assign fire        = i_work_valid &&
                         ((r_count != pcc_pkg::QCNT_W'(pcc_pkg::QDEPTH)) || pop_ok);
    assign o_work_take = fire;

    // evaluate conditions and next pump state
    always_comb begin
        elapsed   = i_work.now - r_start;
        trig      = !r_blocked &&
                    resolve(i_work.kind_trig, i_work.val_trig, r_running, elapsed);
        stop      = resolve(i_work.kind_a, i_work.val_a, r_running, elapsed) ||
                    resolve(i_work.kind_b, i_work.val_b, r_running, elapsed);
        err       = 1'b0;
        n_running = r_running;
        n_start   = r_start;
        n_stop    = r_stop;
        n_blocked = r_blocked;
        if (i_work.oper) begin
            if (stop && trig) begin
                n_blocked = 1'b1;
                err       = 1'b1;
            end else if (trig && !r_running) begin
                n_start   = i_work.now;
                n_running = 1'b1;
            end else if (stop && r_running) begin
                n_stop    = i_work.now;
                n_running = 1'b0;
            end
        end else if (r_running) begin
            n_stop    = i_work.now;
            n_running = 1'b0;
        end
    end

    // build the result word
    always_comb begin
        n_result.pump_on  = n_running;
        n_result.conflict = err;
        if (n_running) begin
            n_result.stopped_for = n_start - n_stop;
            run_diff             = i_work.now - n_start;
        end else begin
            n_result.stopped_for = i_work.now - n_stop;
            run_diff             = n_stop - n_start;
        end
        n_result.running_for = run_diff[pcc_pkg::RUN_W-1:0];
    end

    // pump state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_start   <= '0;
            r_stop    <= '0;
            r_blocked <= 1'b0;
        end else begin
            if (fire) begin
                r_running <= n_running;
                r_start   <= n_start;
                r_stop    <= n_stop;
            end
            // a new trigger word releases the block
            if (i_trig_written) begin
                r_blocked <= 1'b0;
            end else if (fire) begin
                r_blocked <= n_blocked;
            end
        end
    end

    // result queue storage
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_q[r_wr_ptr] <= n_result;
        end
    end

    // result queue pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (fire) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (pop_ok) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (fire && !pop_ok) begin
                r_count <= r_count + 1'b1;
            end else if (pop_ok && !fire) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_pump_on        = r_q[r_rd_ptr].pump_on;
    assign o_conflict_error = r_q[r_rd_ptr].conflict;
    assign o_stopped_for_s  = r_q[r_rd_ptr].stopped_for;
    assign o_running_for_s  = r_q[r_rd_ptr].running_for;

endmodule

// ===== design/pump_condition_controller.sv =====
// ----------------------------------------------------------------------------
// pump_condition_controller
// Pump control from a trigger and two stop conditions, one evaluation per word.
// ----------------------------------------------------------------------------
// Takes one evaluation word per clock while full is low and returns one result
// word for each, in order. A pushed word is classified and stored in the front's
// two-entry queue, then resolved in the state update stage that writes the
// two-entry result queue. The pump state update loops on the running flag,
// block flag and start time inside the back stage, so back-to-back words
// sustain one per cycle as long as pop keeps up; either side may stall
// on its own. Condition registers are written through i_cfg_we, i_cfg_index
// and i_cfg_data, with no wait; index 3 is ignored, and a write of the trigger
// register releases a blocked trigger.
// ----------------------------------------------------------------------------
module pump_condition_controller (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [pcc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pcc_pkg::WORD_W-1:0]         i_cfg_data,
    input  logic                               push,
    output logic                               full,
    input  logic [pcc_pkg::WORD_W-1:0]         i_now_seconds,
    input  logic                               i_operational,
    input  logic                               i_sensor_for_trigger,
    input  logic                               i_sensor_for_stop_a,
    input  logic                               i_sensor_for_stop_b,
    output logic                               empty,
    input  logic                               pop,
    output logic                               o_pump_on,
    output logic                               o_conflict_error,
    output logic [pcc_pkg::WORD_W-1:0]         o_stopped_for_s,
    output logic [pcc_pkg::RUN_W-1:0]          o_running_for_s
);

    pcc_pkg::t_work work;
    logic           work_valid;
    logic           work_take;
    logic           trig_written;

    // a trigger register write clears the block in the back stage
    assign trig_written = i_cfg_we &&
                          (pcc_pkg::t_reg_idx'(i_cfg_index) == pcc_pkg::REG_TRIGGER);

    pcc_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data),
        .i_push               (push),
        .o_full               (full),
        .i_now_seconds        (i_now_seconds),
        .i_operational        (i_operational),
        .i_sensor_for_trigger (i_sensor_for_trigger),
        .i_sensor_for_stop_a  (i_sensor_for_stop_a),
        .i_sensor_for_stop_b  (i_sensor_for_stop_b),
        .o_work               (work),
        .o_work_valid         (work_valid),
        .i_work_take          (work_take)
    );

    pcc_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_trig_written   (trig_written),
        .i_work           (work),
        .i_work_valid     (work_valid),
        .o_work_take      (work_take),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_pump_on        (o_pump_on),
        .o_conflict_error (o_conflict_error),
        .o_stopped_for_s  (o_stopped_for_s),
        .o_running_for_s  (o_running_for_s)
    );

endmodule
